FILE: design/erfc_pkg.sv
`default_nettype none

package erfc_pkg;

    // i/o formats
    localparam int IN_W          = 21;
    localparam int OUT_W         = 18;
    localparam int IO_FRAC       = 16;
    localparam int FRAC_BITS_DEF = 16;

    // exp(-r) series and range reduction
    localparam int EXP_TERMS = 12;
    localparam int K_BITS    = 6;

    // constants scaled by 1e9
    localparam longint BILLION  = 64'sd1000000000;
    localparam longint C9_P     = 64'sd327591100;
    localparam longint C9_LN2   = 64'sd693147181;
    localparam longint C9_A1    = 64'sd254829592;
    localparam longint C9_A2    = -64'sd284496736;
    localparam longint C9_A3    = 64'sd1421413741;
    localparam longint C9_A4    = -64'sd1453152027;
    localparam longint C9_A5    = 64'sd1061405429;

    // c9 * 2^f / 1e9, rounded to nearest with halves upward
    function automatic longint fx_const(input longint c9, input int f);
        longint n;
        begin
            n = 2 * c9 * (64'sd1 <<< f) + BILLION;
            if (n >= 0)
                fx_const = n / (2 * BILLION);
            else
                fx_const = -((-n + 2 * BILLION - 1) / (2 * BILLION));
        end
    endfunction

endpackage

`default_nettype wire

FILE: design/erfc_rational_approx_core.sv
`default_nettype none

// erfc / erf by the classic rational form: t = 1/(1+p|x|), a five-term
// polynomial in t, times exp(-x^2), mirrored for negative x. arg_x is taken
// as signed Q4.16 at any edge where start is high; busy never rises, so a new
// beat may be issued every cycle. each result appears on erfc_value (unsigned
// Q2.16, within [0,2]) and erf_value (signed Q1.16) for one cycle with done
// high, after the input, head, pipeline, product and output registers. the
// latency is set by the longer of two parallel chains, the bit-per-stage
// reciprocal divider plus polynomial, and the range reduction plus the
// twelve-term exp series at two stages a term.
// results are never held back, so the receiver must take every done beat.
module erfc_rational_approx_core #(
    parameter int FRAC_BITS = erfc_pkg::FRAC_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic signed [erfc_pkg::IN_W-1:0] arg_x,
    output logic                                  done,
    output logic        [erfc_pkg::OUT_W-1:0]     erfc_value,
    output logic signed [erfc_pkg::OUT_W-1:0]     erf_value
);

    localparam int F    = FRAC_BITS;
    localparam int AW   = F + 5;          // |x| in Q.F, up to 16.0
    localparam int SW   = F + 9;          // x*x
    localparam int DW   = F + 3;          // 1 + p|x|
    localparam int RW   = 2 * F + 4;      // divider remainder
    localparam int PW   = F + 4;          // polynomial, signed
    localparam int EW   = F + 5;          // range reduction remainder
    localparam int KW   = erfc_pkg::K_BITS;
    localparam int NT   = erfc_pkg::EXP_TERMS;
    localparam int EXP0 = KW;             // first series stage
    localparam int SHS  = KW + 2 * NT;    // final shift stage
    localparam int PLEN = F + 6;
    localparam int ELEN = SHS + 1;
    localparam int LEN  = (PLEN > ELEN) ? PLEN : ELEN;
    localparam int QW   = PW + F + 2;
    localparam int OSH  = 2 * F - erfc_pkg::IO_FRAC;

    localparam logic [F:0]    ONE    = (F + 1)'(1) << F;
    localparam logic [F:0]    P_C    = (F + 1)'(erfc_pkg::fx_const(erfc_pkg::C9_P, F));
    localparam logic [EW-1:0] LN2_C  = EW'(erfc_pkg::fx_const(erfc_pkg::C9_LN2, F));
    localparam logic signed [PW-1:0] A_C [5] = '{
        PW'(erfc_pkg::fx_const(erfc_pkg::C9_A1, F)),
        PW'(erfc_pkg::fx_const(erfc_pkg::C9_A2, F)),
        PW'(erfc_pkg::fx_const(erfc_pkg::C9_A3, F)),
        PW'(erfc_pkg::fx_const(erfc_pkg::C9_A4, F)),
        PW'(erfc_pkg::fx_const(erfc_pkg::C9_A5, F))
    };

    // reciprocal and polynomial path
    typedef struct packed {
        logic                 valid;
        logic                 neg;
        logic [DW-1:0]        dden;
        logic [RW-1:0]        drem;
        logic [F:0]           tq;
        logic signed [PW-1:0] poly;
    } poly_t;

    // exp(-x^2) path
    typedef struct packed {
        logic          ezero;
        logic [EW-1:0] erem;
        logic [KW-1:0] k;
        logic [F:0]    e;
        logic [F:0]    m;
    } exp_t;

    // the receiver cannot stall and every stage advances each cycle
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // input stage: sign and magnitude, moved to the working format
    // ------------------------------------------------------------------
    logic               in_valid_reg;
    logic               in_neg_reg;
    logic [AW-1:0]      in_a_reg;
    logic [AW-1:0]      in_a_next;
    logic [erfc_pkg::IN_W-1:0] ax;

    assign ax = arg_x[erfc_pkg::IN_W-1] ? erfc_pkg::IN_W'(-arg_x) : erfc_pkg::IN_W'(arg_x);

    generate
        if (F >= erfc_pkg::IO_FRAC) begin : g_conv_up
            assign in_a_next = AW'(ax) << (F - erfc_pkg::IO_FRAC);
        end else begin : g_conv_down
            localparam int DS = erfc_pkg::IO_FRAC - F;
            logic [erfc_pkg::IN_W:0] rsum;
            assign rsum      = (erfc_pkg::IN_W + 1)'(ax) + ((erfc_pkg::IN_W + 1)'(1) << (DS - 1));
            assign in_a_next = AW'(rsum >> DS);
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            in_neg_reg   <= 1'b0;
            in_a_reg     <= '0;
        end
        else
        begin
            in_valid_reg <= start;
            in_neg_reg   <= arg_x[erfc_pkg::IN_W-1];
            in_a_reg     <= in_a_next;
        end
    end

    // ------------------------------------------------------------------
    // head stage: denominator 1 + p|x| and square x*x
    // ------------------------------------------------------------------
    poly_t poly_reg [0:LEN];
    exp_t  exp_reg  [0:LEN];
    poly_t poly_next [0:LEN-1];
    exp_t  exp_next  [0:LEN-1];
    poly_t head_poly;
    exp_t  head_exp;

    always_comb
    begin
        logic [2*F+5:0] pa;
        logic [2*AW-1:0] aa;
        logic [DW-1:0]   den;
        logic [SW-1:0]   s;
        pa  = (2 * F + 6)'(P_C) * (2 * F + 6)'(in_a_reg);
        aa  = (2 * AW)'(in_a_reg) * (2 * AW)'(in_a_reg);
        den = DW'(ONE) + DW'((pa + ((2 * F + 6)'(1) << (F - 1))) >> F);
        s   = SW'((aa + ((2 * AW)'(1) << (F - 1))) >> F);

        head_poly.valid = in_valid_reg;
        head_poly.neg   = in_neg_reg;
        head_poly.dden  = den;
        head_poly.drem  = (RW'(1) << (2 * F)) + RW'(den >> 1);
        head_poly.tq    = '0;
        head_poly.poly  = '0;

        // exp underflows to zero once x*x reaches 32
        head_exp.ezero = (s >= (SW'(32) << F));
        head_exp.erem  = head_exp.ezero ? '0 : EW'(s);
        head_exp.k     = '0;
        head_exp.e     = ONE;
        head_exp.m     = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg[0] <= '0;
            exp_reg[0]  <= '0;
        end
        else
        begin
            poly_reg[0] <= head_poly;
            exp_reg[0]  <= head_exp;
        end
    end

    // ------------------------------------------------------------------
    // main pipeline: both paths advance one step per stage
    // ------------------------------------------------------------------
    genvar j;
    generate
        for (j = 0; j < LEN; j++) begin : g_stage

            // reciprocal one quotient bit a stage, then Horner one term a stage
            if (j <= F) begin : g_div
                localparam int B = F - j;
                always_comb
                begin
                    logic [RW-1:0] dsh;
                    poly_next[j] = poly_reg[j];
                    dsh = RW'(poly_reg[j].dden) << B;
                    if (poly_reg[j].drem >= dsh)
                    begin
                        poly_next[j].drem  = poly_reg[j].drem - dsh;
                        poly_next[j].tq[B] = 1'b1;
                    end
                end
            end else if (j <= F + 5) begin : g_horner
                localparam int H = j - F - 1;
                always_comb
                begin
                    logic signed [PW-1:0]    hin;
                    logic signed [PW+F+1:0]  hp;
                    logic signed [PW+F+1:0]  hr;
                    poly_next[j] = poly_reg[j];
                    hin = (H == 0) ? A_C[4] : poly_reg[j].poly;
                    hp  = $signed({1'b0, poly_reg[j].tq}) * hin;
                    hr  = (hp + ((PW + F + 2)'(1) <<< (F - 1))) >>> F;
                    if (H < 4)
                        poly_next[j].poly = PW'(hr) + A_C[(H < 4) ? (3 - H) : 0];
                    else
                        poly_next[j].poly = PW'(hr);
                end
            end else begin : g_poly_hold
                assign poly_next[j] = poly_reg[j];
            end

            // range reduction by ln2, series for exp(-r), then the 2^-k shift
            if (j < EXP0) begin : g_kdiv
                localparam int B = KW - 1 - j;
                always_comb
                begin
                    logic [EW-1:0] lsh;
                    exp_next[j] = exp_reg[j];
                    lsh = LN2_C << B;
                    if (exp_reg[j].erem >= lsh)
                    begin
                        exp_next[j].erem = exp_reg[j].erem - lsh;
                        exp_next[j].k[B] = 1'b1;
                    end
                end
            end else if (j < SHS) begin : g_series
                localparam int TT = j - EXP0;
                localparam int N  = NT - TT / 2;
                localparam int PH = TT % 2;
                localparam int SH = F + 8;
                localparam longint unsigned RECIP_L = ((64'd1 << SH) + 2 * N - 1) / (2 * N);
                localparam logic [F+7:0] RECIP = (F + 8)'(RECIP_L);
                if (PH == 0) begin : g_mul
                    // m = r * e
                    always_comb
                    begin
                        logic [2*F:0] tp;
                        exp_next[j] = exp_reg[j];
                        tp = (2 * F + 1)'(exp_reg[j].erem[F-1:0]) * (2 * F + 1)'(exp_reg[j].e);
                        exp_next[j].m = (F + 1)'((tp + ((2 * F + 1)'(1) << (F - 1))) >> F);
                    end
                end else begin : g_recip
                    // e = 1 - m / n, rounded, by reciprocal multiply
                    always_comb
                    begin
                        logic [F+2:0]    tx;
                        logic [2*F+10:0] rp;
                        exp_next[j] = exp_reg[j];
                        tx = (F + 3)'({exp_reg[j].m, 1'b0}) + (F + 3)'(N);
                        rp = (2 * F + 11)'(tx) * (2 * F + 11)'(RECIP);
                        exp_next[j].e = ONE - (F + 1)'(rp >> SH);
                    end
                end
            end else if (j == SHS) begin : g_shift
                always_comb
                begin
                    logic [63:0] ssum;
                    exp_next[j] = exp_reg[j];
                    ssum = 64'(exp_reg[j].e) + ((64'd1 << exp_reg[j].k) >> 1);
                    exp_next[j].e = exp_reg[j].ezero ? '0 : (F + 1)'(ssum >> exp_reg[j].k);
                end
            end else begin : g_exp_hold
                assign exp_next[j] = exp_reg[j];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    poly_reg[j+1] <= '0;
                    exp_reg[j+1]  <= '0;
                end
                else
                begin
                    poly_reg[j+1] <= poly_next[j];
                    exp_reg[j+1]  <= exp_next[j];
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // product of polynomial and exponential
    // ------------------------------------------------------------------
    logic                 q_valid_reg;
    logic                 q_neg_reg;
    logic signed [QW-1:0] q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg <= 1'b0;
            q_neg_reg   <= 1'b0;
            q_reg       <= '0;
        end
        else
        begin
            q_valid_reg <= poly_reg[LEN].valid;
            q_neg_reg   <= poly_reg[LEN].neg;
            q_reg       <= QW'(poly_reg[LEN].poly) * QW'($signed({1'b0, exp_reg[LEN].e}));
        end
    end

    // ------------------------------------------------------------------
    // output stage: round to Q.16, clamp, mirror for negative x
    // ------------------------------------------------------------------
    logic [erfc_pkg::OUT_W-1:0] erfc_next;
    logic [erfc_pkg::OUT_W-1:0] erf_next;

    always_comb
    begin
        logic signed [QW-1:0]       qr;
        logic [erfc_pkg::OUT_W-1:0] v;
        qr = (q_reg + (QW'(1) <<< (OSH - 1))) >>> OSH;
        priority if (qr < 0)
            v = '0;
        else if (qr > (QW'(1) <<< erfc_pkg::IO_FRAC))
            v = erfc_pkg::OUT_W'(1) << erfc_pkg::IO_FRAC;
        else
            v = erfc_pkg::OUT_W'(qr);
        erfc_next = q_neg_reg ? ((erfc_pkg::OUT_W'(2) << erfc_pkg::IO_FRAC) - v) : v;
        erf_next  = (erfc_pkg::OUT_W'(1) << erfc_pkg::IO_FRAC) - erfc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done       <= 1'b0;
            erfc_value <= '0;
            erf_value  <= '0;
        end
        else
        begin
            done       <= q_valid_reg;
            erfc_value <= erfc_next;
            erf_value  <= $signed(erf_next);
        end
    end

endmodule

`default_nettype wire

FILE: tb/sv/erfc_rational_approx_core_tb.sv
`default_nettype none

module erfc_rational_approx_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB        = erfc_pkg::FRAC_BITS_DEF;
    localparam int IN_W      = erfc_pkg::IN_W;
    localparam int OUT_W     = erfc_pkg::OUT_W;
    localparam int IO_FRAC   = erfc_pkg::IO_FRAC;
    // pipeline depth of the core
    localparam int LATENCY   = 35;
    localparam int IDLE_LIM  = 2000;

    // clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #1 clk = ~clk;

    // stimulus side
    logic                    start = 1'b0;
    logic signed [IN_W-1:0]  arg_x = '0;
    logic                    busy;
    logic                    done;
    logic        [OUT_W-1:0] erfc_value;
    logic signed [OUT_W-1:0] erf_value;

    erfc_rational_approx_core #(.FRAC_BITS(FB)) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .arg_x      (arg_x),
        .done       (done),
        .erfc_value (erfc_value),
        .erf_value  (erf_value)
    );

    // expected results, oldest first
    logic [OUT_W-1:0] erfc_q[$];
    logic [OUT_W-1:0] erf_q[$];
    int errors = 0;
    int beats_sent = 0;
    int beats_seen = 0;
    int idle_cycles = 0;

    // rounding helpers in the working format
    function automatic longint fl_shift(longint v, int s);
        if (v >= 0)
            return v >>> s;
        return -((-v + ((64'sd1 <<< s) - 1)) >>> s);
    endfunction

    function automatic longint rnd_shift(longint v, int s);
        if (s == 0)
            return v;
        return fl_shift(v + (64'sd1 <<< (s - 1)), s);
    endfunction

    function automatic longint rnd_div(longint n, longint d);
        longint m;
        m = 2 * n + d;
        if (m >= 0)
            return m / (2 * d);
        return -((-m + 2 * d - 1) / (2 * d));
    endfunction

    function automatic longint qmul(longint a, longint b);
        return rnd_shift(a * b, FB);
    endfunction

    function automatic longint qconst(longint c9);
        return rnd_div(c9 * (64'sd1 <<< FB), erfc_pkg::BILLION);
    endfunction

    // exp(-s), s >= 0, by range reduction and a twelve-term series
    function automatic longint exp_neg(longint s);
        longint one, ln2, k, r, e;
        one = 64'sd1 <<< FB;
        ln2 = qconst(erfc_pkg::C9_LN2);
        if (s >= 32 * one)
            return 0;
        k = s / ln2;
        r = s - k * ln2;
        e = one;
        for (int n = erfc_pkg::EXP_TERMS; n >= 1; n--)
            e = one - rnd_div(qmul(r, e), longint'(n));
        return rnd_shift(e, int'(k));
    endfunction

    // erfc and erf for one argument, both at 18 bits
    task automatic predict_erfc(input logic signed [IN_W-1:0] x);
        longint one, xv, ax, a, den, t, poly, s, e, v, ec, ef;
        longint coef[5];
        one = 64'sd1 <<< FB;
        coef[0] = erfc_pkg::C9_A1; coef[1] = erfc_pkg::C9_A2; coef[2] = erfc_pkg::C9_A3;
        coef[3] = erfc_pkg::C9_A4; coef[4] = erfc_pkg::C9_A5;
        xv = longint'(x);
        ax = (xv < 0) ? -xv : xv;
        if (FB >= IO_FRAC)
            a = ax * (64'sd1 <<< (FB - IO_FRAC));
        else
            a = rnd_shift(ax, IO_FRAC - FB);
        den = one + qmul(qconst(erfc_pkg::C9_P), a);
        t = ((one * one) + den / 2) / den;
        poly = qconst(coef[4]);
        for (int i = 3; i >= 0; i--)
            poly = qconst(coef[i]) + qmul(t, poly);
        poly = qmul(t, poly);
        s = qmul(a, a);
        e = exp_neg(s);
        v = rnd_shift(poly * e, 2 * FB - IO_FRAC);
        if (v < 0)
            v = 0;
        if (v > (64'sd1 <<< IO_FRAC))
            v = 64'sd1 <<< IO_FRAC;
        // negative side mirrors about one
        ec = (xv < 0) ? ((64'sd2 <<< IO_FRAC) - v) : v;
        ef = (64'sd1 <<< IO_FRAC) - ec;
        erfc_q.insert(erfc_q.size(), ec[OUT_W-1:0]);
        erf_q.insert(erf_q.size(), ef[OUT_W-1:0]);
    endtask

    // one beat into the core, after a random gap when gaps is set
    task automatic send_arg(input logic signed [IN_W-1:0] x, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(11, 0) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        arg_x <= x;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_erfc(x);
        beats_sent++;
        @(negedge clk);
    endtask

    // result checker, sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            beats_seen++;
            if (erfc_q.size() == 0)
            begin
                $error("result beat with nothing expected: erfc %0d erf %0d",
                       erfc_value, erf_value);
                errors++;
            end
            else
            begin
                logic [OUT_W-1:0] ec, ef;
                ec = erfc_q.pop_front();
                ef = erf_q.pop_front();
                if (erfc_value !== ec)
                begin
                    $error("erfc_value: expected %0d actual %0d", ec, erfc_value);
                    errors++;
                end
                if (erf_value !== ef)
                begin
                    $error("erf_value: expected %0d actual %0d",
                           $signed(ef), erf_value);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no accepted beat either way
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIM)
        begin
            $display("timeout: no beat accepted for %0d cycles", IDLE_LIM);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // extremes of the argument, zero, the sign boundary and underflow
    task automatic test_directed();
        logic signed [IN_W-1:0] pts[$];
        pts = '{21'sh100000, 21'sh0FFFFF, 21'sd0, 21'sd1, -21'sd1,
                21'sd65536, -21'sd65536, 21'sd32768, -21'sd32768,
                21'sd131072, -21'sd131072, 21'sd262144, -21'sd262144,
                21'sd370000, -21'sd370000, 21'sd400000, -21'sd400000,
                21'sd524288, -21'sd524288, 21'sh155555, 21'h0AAAAA,
                21'sd16384, -21'sd16384};
        foreach (pts[i])
            send_arg(pts[i], i > 12);
    endtask

    // mostly the interesting range -2 <= x < 2, some across the full field
    task automatic test_random();
        logic signed [IN_W-1:0] x;
        bit gaps;
        for (int i = 0; i < 500; i++)
        begin
            // bursts of back-to-back beats between gapped stretches
            gaps = ((i / 40) % 2) == 1;
            if ($urandom_range(3, 0) == 0)
                x = IN_W'($urandom());
            else
                x = $signed(21'($urandom_range(262143, 0))) - 21'sd131072;
            send_arg(x, gaps);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (erfc_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random();
        drain_results();
        $display("sent %0d arguments, checked %0d result beats", beats_sent, beats_seen);
        $display("covered both signs, full-range extremes and exp underflow");
        if (errors == 0 && erfc_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
